FILE: hdl/bsck_pkg.sv
package bsck_pkg;

    localparam int EDGE_W    = 8;
    localparam int BOX_W     = 3 * EDGE_W;
    localparam int KEY_W     = 24;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int RANK_W    = 6;
    localparam int DEPTH_DEF = 16;

    // key_mode codes
    localparam logic MODE_VOLUME = 1'b0;
    localparam logic MODE_WRAP   = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [BOX_W-1:0] box;
    } cell_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [KEY_W-1:0] key;
        logic [BOX_W-1:0] box;
    } key_item_t;

    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [KEY_W-1:0] key;
        logic [BOX_W-1:0] box;
    } chain_ctl_t;

endpackage

FILE: hdl/bsck_key.sv
module bsck_key (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         mode,
    input  logic [bsck_pkg::EDGE_W-1:0]  a,
    input  logic [bsck_pkg::EDGE_W-1:0]  b,
    input  logic [bsck_pkg::EDGE_W-1:0]  c,
    input  logic                         last,
    output bsck_pkg::key_item_t          item
);
    import bsck_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic [PROD_W-1:0]    s1_prod_reg;
    logic [PROD_W-1:0]    s1_prod_next;
    logic [EDGE_W-1:0]    s1_c_reg;
    logic [BOX_W-1:0]     s1_box_reg;
    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic [KEY_W-1:0]     s2_key_reg;
    logic [KEY_W-1:0]     s2_key_next;
    logic [BOX_W-1:0]     s2_box_reg;
    logic [PROD_W+EDGE_W-1:0] full_prod;

    // first factor: a*b, or 2*(a+b)
    always_comb
    begin
        if (mode == MODE_WRAP)
        begin
            s1_prod_next = PROD_W'({1'b0, a} + {1'b0, b}) << 1;
        end
        else
        begin
            s1_prod_next = PROD_W'(a) * PROD_W'(b);
        end
    end

    assign full_prod   = (PROD_W+EDGE_W)'(s1_prod_reg) * (PROD_W+EDGE_W)'(s1_c_reg);
    assign s2_key_next = full_prod[KEY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= load;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= s1_prod_next;
        s1_c_reg    <= c;
        s1_box_reg  <= {c, b, a};
        s1_last_reg <= last;
        s2_key_reg  <= s2_key_next;
        s2_box_reg  <= s1_box_reg;
        s2_last_reg <= s1_last_reg;
    end

    assign item.valid = s2_valid_reg;
    assign item.last  = s2_last_reg;
    assign item.key   = s2_key_reg;
    assign item.box   = s2_box_reg;

endmodule

FILE: hdl/bsck_cell.sv
module bsck_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsck_pkg::chain_ctl_t ctl,
    input  bsck_pkg::cell_t      prev_cell,
    input  logic                 prev_le,
    input  bsck_pkg::cell_t      next_cell,
    output bsck_pkg::cell_t      q,
    output logic                 le
);
    import bsck_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [BOX_W-1:0] box_reg;
    cell_t            cell_next;

    assign q.valid = valid_reg;
    assign q.key   = key_reg;
    assign q.box   = box_reg;

    // equal keys stay ahead of the new box: keeps the order stable
    assign le = valid_reg && (key_reg <= ctl.key);

    always_comb
    begin
        cell_next = q;
        if (ctl.pop)
        begin
            cell_next = next_cell;
        end
        else if (ctl.ins)
        begin
            if (!prev_le)
            begin
                cell_next = prev_cell;
            end
            else if (!le)
            begin
                cell_next.valid = 1'b1;
                cell_next.key   = ctl.key;
                cell_next.box   = ctl.box;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= cell_next.key;
        box_reg <= cell_next.box;
    end

endmodule

FILE: hdl/box_sort_by_computed_key.sv
// Box sorter with a computed key.
// Input channel (in_valid/in_ready): one box per transfer, edges edge_a..edge_c,
// last_in closes the set. Boxes load at one per cycle; each key goes through a
// two-stage multiply (a*b or 2*(a+b), then times c) and is inserted into a
// sorted chain of DEPTH cells when it leaves the second stage. Boxes past DEPTH
// are dropped and overflow is set for the set. After the last box the input
// stalls while the key pipeline empties and rank 0 is placed in the output
// register, and also while that register is still held by the receiver. Every
// further input transfer (payload ignored) pops the next rank, one per cycle
// while the output is free, until the set is done; then loading resumes.
// Output channel (out_valid/out_ready): one registered result per transfer.
// While the receiver stalls, the head of the chain waits and in_ready is low
// during draining, so nothing is lost. cfg_wr_en/cfg_wr_data set key_mode
// (0: a*b*c, 1: 2*(a+b)*c); write only while idle.
// Reset clears the chain valid bits, counters, overflow flag and key_mode.
module box_sort_by_computed_key #(
    parameter int DEPTH = bsck_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bsck_pkg::EDGE_W-1:0]  edge_a,
    input  logic [bsck_pkg::EDGE_W-1:0]  edge_b,
    input  logic [bsck_pkg::EDGE_W-1:0]  edge_c,
    input  logic                         last_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bsck_pkg::EDGE_W-1:0]  out_edge_a,
    output logic [bsck_pkg::EDGE_W-1:0]  out_edge_b,
    output logic [bsck_pkg::EDGE_W-1:0]  out_edge_c,
    output logic [bsck_pkg::KEY_W-1:0]   sort_key,
    output logic [bsck_pkg::RANK_W-1:0]  rank,
    output logic                         last_out,
    output logic                         overflow
);
    import bsck_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic              mode_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     pos_next;
    logic              ov_reg;
    logic              ov_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BOX_W-1:0]  out_box_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [RANK_W-1:0] out_rank_reg;
    logic              out_last_reg;
    logic              out_ov_reg;

    logic              in_xfer;
    logic              slot_free;
    logic              pop;
    logic              is_final;
    logic              full;
    key_item_t         item;
    chain_ctl_t        chain_ctl;
    cell_t             cell_q [DEPTH];
    logic              cell_le [DEPTH];

    assign slot_free = !out_valid_reg || out_ready;
    assign full      = (cnt_reg == CW'(DEPTH));
    assign is_final  = ((pos_reg + CW'(1)) == cnt_reg);

    always_comb
    begin
        in_ready = 1'b0;
        unique case (state_reg) inside
            ST_LOAD:  in_ready = 1'b1;
            ST_DRAIN: in_ready = slot_free;
            ST_WAIT,
            ST_EMIT:  in_ready = 1'b0;
            default:  in_ready = 1'b0;
        endcase
    end

    assign in_xfer = in_valid && in_ready;
    assign pop     = ((state_reg == ST_EMIT) && slot_free) ||
                     ((state_reg == ST_DRAIN) && in_xfer);

    bsck_key u_key (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (in_xfer && (state_reg == ST_LOAD)),
        .mode  (mode_reg),
        .a     (edge_a),
        .b     (edge_b),
        .c     (edge_c),
        .last  (last_in),
        .item  (item)
    );

    assign chain_ctl.ins = item.valid && !full;
    assign chain_ctl.pop = pop;
    assign chain_ctl.key = item.key;
    assign chain_ctl.box = item.box;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_t prev_c;
            cell_t next_c;
            logic  prev_l;
            if (gi == 0)
            begin : g_head
                assign prev_c = '0;
                assign prev_l = 1'b1;
            end
            else
            begin : g_body
                assign prev_c = cell_q[gi-1];
                assign prev_l = cell_le[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_c = '0;
            end
            else
            begin : g_mid
                assign next_c = cell_q[gi+1];
            end
            bsck_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (chain_ctl),
                .prev_cell (prev_c),
                .prev_le   (prev_l),
                .next_cell (next_c),
                .q         (cell_q[gi]),
                .le        (cell_le[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        ov_next        = ov_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        if (item.valid)
        begin
            if (full)
            begin
                ov_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
        unique case (state_reg) inside
            ST_LOAD:
            begin
                if (in_xfer && last_in)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (item.valid && item.last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT,
            ST_DRAIN:
            begin
                if (pop)
                begin
                    if (is_final)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        pos_next   = '0;
                        ov_next    = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                        pos_next   = pos_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            mode_reg      <= MODE_VOLUME;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            ov_reg        <= ov_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_box_reg  <= cell_q[0].box;
            out_key_reg  <= cell_q[0].key;
            out_rank_reg <= RANK_W'(pos_reg);
            out_last_reg <= is_final;
            out_ov_reg   <= ov_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_edge_a = out_box_reg[EDGE_W-1:0];
    assign out_edge_b = out_box_reg[2*EDGE_W-1:EDGE_W];
    assign out_edge_c = out_box_reg[3*EDGE_W-1:2*EDGE_W];
    assign sort_key   = out_key_reg;
    assign rank       = out_rank_reg;
    assign last_out   = out_last_reg;
    assign overflow   = out_ov_reg;

    a_no_ins_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(chain_ctl.ins && chain_ctl.pop))
        else $error("insert and pop in the same cycle");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("box count beyond capacity");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cell_q[0].valid)
        else $error("pop from an empty chain");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == ST_EMIT) || ($past(state_reg) == ST_DRAIN))
        else $error("result raised outside of draining");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (pos_reg < cnt_reg))
        else $error("drain position past set length");

endmodule
